[rtl/core/gvfm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvfm_pkg
// Shared types and command codes of the greedy voxel face mesher.
// ----------------------------------------------------------------------------
package gvfm_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_FETCH = 2'd2;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_START,
    OP_FETCH
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] x;
    logic [3:0] y;
    logic [3:0] z;
    logic       empty;
    logic       in_range;
  } cmd_t;

endpackage

[rtl/core/gvfm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvfm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gvfm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/gvfm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvfm_front
// Accepts commands, decodes and range-checks them, and queues them for the
// sweep engine.
// ----------------------------------------------------------------------------
module gvfm_front #(
  parameter int SIZE_X = 16,
  parameter int SIZE_Y = 16,
  parameter int SIZE_Z = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_command,
  input  logic [3:0]          in_voxel_x,
  input  logic [3:0]          in_voxel_y,
  input  logic [3:0]          in_voxel_z,
  input  logic                in_is_empty,
  output logic                q_valid,
  output gvfm_pkg::cmd_t      q_cmd,
  input  logic                q_pop
);
  import gvfm_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entry_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  cmd_t          dec;
  logic          keep;
  logic          push;
  logic          pop;

  always_comb begin
    dec.x        = in_voxel_x;
    dec.y        = in_voxel_y;
    dec.z        = in_voxel_z;
    dec.empty    = in_is_empty;
    dec.in_range = (32'(in_voxel_x) < SIZE_X) && (32'(in_voxel_y) < SIZE_Y) &&
                   (32'(in_voxel_z) < SIZE_Z);
    dec.op       = OP_WRITE;
    keep         = 1'b1;
    unique case (in_command)
      CMD_WRITE: dec.op = OP_WRITE;
      CMD_START: dec.op = OP_START;
      CMD_FETCH: dec.op = OP_FETCH;
      default:   keep = 1'b0;  // drop the no-op code
    endcase
  end

  assign in_ready = (count_r != CW'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready && keep;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (count_r != '0);
  assign q_cmd    = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        entry_r[wr_ptr_r] <= dec;
        wr_ptr_r <= (32'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[rtl/core/gvfm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvfm_back
// Sweep engine: voxel store, slice mask build and greedy rectangle walk,
// with the result register.
// ----------------------------------------------------------------------------
module gvfm_back #(
  parameter int SIZE_X = 16,
  parameter int SIZE_Y = 16,
  parameter int SIZE_Z = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  gvfm_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_quad_valid,
  output logic [4:0]     out_origin_x,
  output logic [4:0]     out_origin_y,
  output logic [4:0]     out_origin_z,
  output logic [4:0]     out_span_u,
  output logic [4:0]     out_span_v,
  output logic [2:0]     out_face_side
);
  import gvfm_pkg::*;

  localparam int MAXS  = (SIZE_X > SIZE_Y) ? ((SIZE_X > SIZE_Z) ? SIZE_X : SIZE_Z)
                                           : ((SIZE_Y > SIZE_Z) ? SIZE_Y : SIZE_Z);
  localparam int MW    = $clog2(MAXS);
  localparam int SW    = $clog2(MAXS + 1);
  localparam int XW    = $clog2(SIZE_X);
  localparam int YW    = $clog2(SIZE_Y);
  localparam int ZW    = $clog2(SIZE_Z);
  localparam int VAW   = XW + YW + ZW;
  localparam int MAW   = 2 * MW;

  typedef enum logic [3:0] {
    S_IDLE, S_LD_A, S_LD_B, S_LD_C, S_SC_CHK, S_SC_RD,
    S_W_RD, S_W_CHK, S_H_RD, S_H_CHK, S_CLR
  } state_t;

  state_t        state_r;
  logic          busy_r;
  logic          back_r;
  logic [1:0]    axis_r;
  logic [SW-1:0] slice_r;
  logic [SW-1:0] row_r;
  logic [SW-1:0] col_r;
  logic [SW-1:0] w_r;
  logic [SW-1:0] h_r;
  logic [SW-1:0] k_r;
  logic [SW-1:0] l_r;
  logic          e0_r;
  logic          ret_scan_r;
  logic          out_valid_r;
  logic          out_quad_valid_r;
  logic [4:0]    out_origin_x_r;
  logic [4:0]    out_origin_y_r;
  logic [4:0]    out_origin_z_r;
  logic [4:0]    out_span_u_r;
  logic [4:0]    out_span_v_r;
  logic [2:0]    out_face_side_r;

  logic [SW-1:0]  du;
  logic [SW-1:0]  dv;
  logic [SW-1:0]  dd;
  logic [SW-1:0]  sel_s;
  logic [3*SW-1:0] ld_c;
  logic [3*SW-1:0] em_c;
  logic [SW:0]    col_w;
  logic [SW:0]    row_h;
  logic [SW:0]    col_k;
  logic [SW:0]    row_l;
  logic [SW:0]    slice_inc;
  logic           k_last;
  logic           l_last;
  logic           has0;
  logic           has1;
  logic           marked;

  logic           vox_we;
  logic [VAW-1:0] vox_waddr;
  logic [VAW-1:0] vox_raddr;
  logic           vox_rdata;
  logic           msk_we;
  logic           msk_wdata;
  logic [MAW-1:0] msk_addr;
  logic           msk_rdata;

  function automatic logic [3*SW-1:0] coord_map(input logic [1:0] d, input logic [SW-1:0] s,
                                                input logic [SW-1:0] i,
                                                input logic [SW-1:0] j);
    logic [3*SW-1:0] r;
    unique case (d)
      2'd1:    r = {i, s, j};      // {z, y, x}
      2'd2:    r = {s, j, i};
      default: r = {j, i, s};
    endcase
    return r;
  endfunction

  always_comb begin
    unique case (axis_r)
      2'd1: begin
        du = SW'(SIZE_Z); dv = SW'(SIZE_X); dd = SW'(SIZE_Y);
      end
      2'd2: begin
        du = SW'(SIZE_X); dv = SW'(SIZE_Y); dd = SW'(SIZE_Z);
      end
      default: begin
        du = SW'(SIZE_Y); dv = SW'(SIZE_Z); dd = SW'(SIZE_X);
      end
    endcase
  end

  assign sel_s     = (state_r == S_LD_A) ? slice_r - 1'b1 : slice_r;
  assign ld_c      = coord_map(axis_r, sel_s, col_r, row_r);
  assign em_c      = coord_map(axis_r, slice_r, col_r, row_r);
  assign col_w     = {1'b0, col_r} + {1'b0, w_r};
  assign row_h     = {1'b0, row_r} + {1'b0, h_r};
  assign col_k     = {1'b0, col_r} + {1'b0, k_r};
  assign row_l     = {1'b0, row_r} + {1'b0, l_r};
  assign slice_inc = {1'b0, slice_r} + 1'b1;
  assign k_last    = (({1'b0, k_r} + 1'b1) == {1'b0, w_r});
  assign l_last    = (({1'b0, l_r} + 1'b1) == {1'b0, h_r});
  assign has0      = (slice_r != '0);
  assign has1      = (slice_r < dd);
  assign marked    = back_r ? (has1 && vox_rdata && !(has0 && e0_r))
                            : (has0 && e0_r && !(has1 && vox_rdata));

  assign q_pop     = (state_r == S_IDLE) && q_valid && !out_valid_r;

  // voxel store port control
  assign vox_we    = q_pop && (q_cmd.op == OP_WRITE) && q_cmd.in_range;
  assign vox_waddr = {ZW'(q_cmd.z), YW'(q_cmd.y), XW'(q_cmd.x)};
  assign vox_raddr = {ld_c[2*SW +: ZW], ld_c[SW +: YW], ld_c[0 +: XW]};

  // slice mask port control
  always_comb begin
    msk_we    = 1'b0;
    msk_wdata = 1'b0;
    msk_addr  = {row_r[MW-1:0], col_r[MW-1:0]};
    unique case (state_r)
      S_LD_C: begin
        msk_we    = 1'b1;
        msk_wdata = marked;
      end
      S_W_RD:  msk_addr = {row_r[MW-1:0], col_w[MW-1:0]};
      S_H_RD:  msk_addr = {row_h[MW-1:0], col_k[MW-1:0]};
      S_CLR: begin
        msk_we   = 1'b1;
        msk_addr = {row_l[MW-1:0], col_k[MW-1:0]};
      end
      default: ;
    endcase
  end

  gvfm_ram #(.WIDTH(1), .DEPTH(1 << VAW)) u_voxel_ram (
    .clk   (clk),
    .we    (vox_we),
    .waddr (vox_waddr),
    .wdata (q_cmd.empty),
    .raddr (vox_raddr),
    .rdata (vox_rdata)
  );

  gvfm_ram #(.WIDTH(1), .DEPTH(1 << MAW)) u_mask_ram (
    .clk   (clk),
    .we    (msk_we),
    .waddr (msk_addr),
    .wdata (msk_wdata),
    .raddr (msk_addr),
    .rdata (msk_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      back_r      <= 1'b1;
      axis_r      <= '0;
      slice_r     <= '0;
      row_r       <= '0;
      col_r       <= '0;
      ret_scan_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            unique case (q_cmd.op)
              OP_START: begin
                back_r     <= 1'b1;
                axis_r     <= '0;
                slice_r    <= '0;
                busy_r     <= 1'b1;
                row_r      <= '0;
                col_r      <= '0;
                ret_scan_r <= 1'b0;
                state_r    <= S_LD_A;
              end
              OP_FETCH: begin
                if (busy_r) begin
                  state_r <= S_SC_CHK;
                end else begin
                  out_valid_r      <= 1'b1;
                  out_quad_valid_r <= 1'b0;
                  out_origin_x_r   <= '0;
                  out_origin_y_r   <= '0;
                  out_origin_z_r   <= '0;
                  out_span_u_r     <= '0;
                  out_span_v_r     <= '0;
                  out_face_side_r  <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_LD_A: state_r <= S_LD_B;
        S_LD_B: begin
          e0_r    <= vox_rdata;
          state_r <= S_LD_C;
        end
        S_LD_C: begin
          if (({1'b0, col_r} + 1'b1) < {1'b0, du}) begin
            col_r   <= col_r + 1'b1;
            state_r <= S_LD_A;
          end else begin
            col_r <= '0;
            if (({1'b0, row_r} + 1'b1) < {1'b0, dv}) begin
              row_r   <= row_r + 1'b1;
              state_r <= S_LD_A;
            end else begin
              row_r   <= '0;
              state_r <= ret_scan_r ? S_SC_CHK : S_IDLE;
            end
          end
        end
        S_SC_CHK: begin
          if (row_r >= dv) begin
            // next slice, axis or pass
            row_r      <= '0;
            col_r      <= '0;
            ret_scan_r <= 1'b1;
            state_r    <= S_LD_A;
            if (slice_inc > {1'b0, dd}) begin
              slice_r <= '0;
              if (axis_r == 2'd2) begin
                axis_r <= '0;
                if (back_r) begin
                  back_r <= 1'b0;
                end else begin
                  busy_r           <= 1'b0;
                  back_r           <= 1'b1;
                  state_r          <= S_IDLE;
                  out_valid_r      <= 1'b1;
                  out_quad_valid_r <= 1'b0;
                  out_origin_x_r   <= '0;
                  out_origin_y_r   <= '0;
                  out_origin_z_r   <= '0;
                  out_span_u_r     <= '0;
                  out_span_v_r     <= '0;
                  out_face_side_r  <= '0;
                end
              end else begin
                axis_r <= axis_r + 1'b1;
              end
            end else begin
              slice_r <= slice_inc[SW-1:0];
            end
          end else if (col_r >= du) begin
            row_r <= row_r + 1'b1;
            col_r <= '0;
          end else begin
            state_r <= S_SC_RD;
          end
        end
        S_SC_RD: begin
          if (!msk_rdata) begin
            col_r   <= col_r + 1'b1;
            state_r <= S_SC_CHK;
          end else begin
            w_r     <= SW'(1);
            state_r <= S_W_RD;
          end
        end
        S_W_RD: begin
          if (col_w < {1'b0, du}) begin
            state_r <= S_W_CHK;
          end else begin
            h_r     <= SW'(1);
            k_r     <= '0;
            state_r <= S_H_RD;
          end
        end
        S_W_CHK: begin
          if (msk_rdata) begin
            w_r     <= w_r + 1'b1;
            state_r <= S_W_RD;
          end else begin
            h_r     <= SW'(1);
            k_r     <= '0;
            state_r <= S_H_RD;
          end
        end
        S_H_RD: begin
          if (row_h < {1'b0, dv}) begin
            state_r <= S_H_CHK;
          end else begin
            l_r     <= '0;
            k_r     <= '0;
            state_r <= S_CLR;
          end
        end
        S_H_CHK: begin
          if (!msk_rdata) begin
            l_r     <= '0;
            k_r     <= '0;
            state_r <= S_CLR;
          end else if (k_last) begin
            h_r     <= h_r + 1'b1;
            k_r     <= '0;
            state_r <= S_H_RD;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_H_RD;
          end
        end
        S_CLR: begin
          if (k_last) begin
            k_r <= '0;
            if (l_last) begin
              out_valid_r      <= 1'b1;
              out_quad_valid_r <= 1'b1;
              out_origin_x_r   <= 5'(em_c[0 +: SW]);
              out_origin_y_r   <= 5'(em_c[SW +: SW]);
              out_origin_z_r   <= 5'(em_c[2*SW +: SW]);
              out_span_u_r     <= 5'(w_r);
              out_span_v_r     <= 5'(h_r);
              out_face_side_r  <= {axis_r, !back_r};
              col_r            <= col_w[SW-1:0];
              state_r          <= S_IDLE;
            end else begin
              l_r <= l_r + 1'b1;
            end
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_quad_valid = out_quad_valid_r;
  assign out_origin_x   = out_origin_x_r;
  assign out_origin_y   = out_origin_y_r;
  assign out_origin_z   = out_origin_z_r;
  assign out_span_u     = out_span_u_r;
  assign out_span_v     = out_span_v_r;
  assign out_face_side  = out_face_side_r;

endmodule

[rtl/core/greedy_voxel_face_mesher_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_voxel_face_mesher_core
// Binary voxel volume with a greedy face mesher that returns one quad per
// fetch command.
//
// Input channel (in_valid/in_ready): command 0 writes one voxel empty flag,
// 1 starts a sweep (back pass, then front pass, axes 0..2), 2 fetches the
// next quad, 3 is dropped. Each fetch yields exactly one result on the out_
// channel: a quad, or an all-zero end marker once the sweep is done or when
// no sweep runs. Results leave in command order.
// Commands pass through a two-entry queue into a sequential sweep engine.
// A start rebuilds the first slice mask, reading two voxels and writing
// one mask bit per mask cell. A fetch walks the mask: it tests cells,
// clears the cells of the quad it finds and rebuilds the full mask for
// each slice it crosses, so its latency is data dependent.
// While a result waits in the output register the engine takes no further
// command; the queue keeps accepting until it is full.
// Reset empties the queue and idles the sweep; voxel contents are kept and
// must be written before a sweep reads them.
// ----------------------------------------------------------------------------
module greedy_voxel_face_mesher_core #(
  parameter int SIZE_X = 16,
  parameter int SIZE_Y = 16,
  parameter int SIZE_Z = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_command,
  input  logic [3:0] in_voxel_x,
  input  logic [3:0] in_voxel_y,
  input  logic [3:0] in_voxel_z,
  input  logic       in_is_empty,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_quad_valid,
  output logic [4:0] out_origin_x,
  output logic [4:0] out_origin_y,
  output logic [4:0] out_origin_z,
  output logic [4:0] out_span_u,
  output logic [4:0] out_span_v,
  output logic [2:0] out_face_side
);
  import gvfm_pkg::*;

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  gvfm_front #(.SIZE_X(SIZE_X), .SIZE_Y(SIZE_Y), .SIZE_Z(SIZE_Z)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_command  (in_command),
    .in_voxel_x  (in_voxel_x),
    .in_voxel_y  (in_voxel_y),
    .in_voxel_z  (in_voxel_z),
    .in_is_empty (in_is_empty),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop)
  );

  gvfm_back #(.SIZE_X(SIZE_X), .SIZE_Y(SIZE_Y), .SIZE_Z(SIZE_Z)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_quad_valid (out_quad_valid),
    .out_origin_x   (out_origin_x),
    .out_origin_y   (out_origin_y),
    .out_origin_z   (out_origin_z),
    .out_span_u     (out_span_u),
    .out_span_v     (out_span_v),
    .out_face_side  (out_face_side)
  );

endmodule
